>>> rtl/core/tfcl_pkg.sv
package tfcl_pkg;

    localparam int TFCL_DEPTH = 64;

    localparam int TIME_W   = 48;
    localparam int FREQ_W   = 40;
    localparam int PART_W   = 2;
    localparam int PSD_W    = 32;
    localparam int COUNT_W  = 7;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 4;

    localparam logic [COUNT_W-1:0] MAX_CELLS_RST = 7'd64;
    localparam logic [PART_W-1:0]  PART_INVALID  = 2'd3;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_UNUSED = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 4'd0,
        ST_TIME     = 4'd1,
        ST_FREQ     = 4'd2,
        ST_PART     = 4'd3,
        ST_SCALE    = 4'd4,
        ST_FULL     = 4'd5,
        ST_ORDER    = 4'd6,
        ST_OVERLAP  = 4'd7,
        ST_EMPTY    = 4'd8,
        ST_NOTFOUND = 4'd9
    } t_status;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic [FREQ_W-1:0] lower_freq;
        logic [FREQ_W-1:0] upper_freq;
        logic [PSD_W-1:0]  psd_scale;
        logic [PART_W-1:0] part_code;
    } t_cell;

    typedef struct packed {
        logic t_ge_start;
        logic t_eq_start;
        logic t_lt_end;
        logic f_ge_lower;
        logic f_lt_upper;
    } t_cmp_flags;

endpackage

>>> rtl/core/tfcl_cell_mem.sv
module tfcl_cell_mem
    import tfcl_pkg::*;
#(
    parameter int DEPTH = TFCL_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_cell         i_wr_entry,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_cell         o_rd_entry
);

    t_cell r_mem [0:DEPTH-1];
    t_cell r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule

>>> rtl/core/tfcl_cmp_unit.sv
module tfcl_cmp_unit
    import tfcl_pkg::*;
(
    input  logic [TIME_W-1:0] i_query_time,
    input  logic [FREQ_W-1:0] i_query_freq,
    input  t_cell             i_entry,
    output t_cmp_flags        o_flags
);

    // Shared by lookup containment and by append ordering against the last cell.
    always_comb begin
        o_flags.t_ge_start = (i_query_time >= i_entry.start_time);
        o_flags.t_eq_start = (i_query_time == i_entry.start_time);
        o_flags.t_lt_end   = (i_query_time <  i_entry.end_time);
        o_flags.f_ge_lower = (i_query_freq >= i_entry.lower_freq);
        o_flags.f_lt_upper = (i_query_freq <  i_entry.upper_freq);
    end

endmodule

>>> rtl/core/time_frequency_cell_lookup_core.sv
// Time-frequency cell table with first-match lookup.
//
// Input channel (i_in_valid / o_in_stall): one item per transfer, carrying an
// opcode and the cell or query fields. Clear empties the table, append checks
// a cell and stores it at the end, lookup returns the first stored cell that
// holds the query time and frequency. Every item yields exactly one result.
// Output channel (o_out_valid / i_out_stall): status, cell index, part, scale
// and the cell count after the item. The result waits in an output register,
// so the next item is taken while an earlier result is still stalled.
// Configuration (i_cfg_valid / o_cfg_ready): writes max_cells; always ready.
// Clear, an unused opcode and a lookup of an empty table go straight to the
// result; append passes a check step and, on a non-empty table, a compare
// against the last cell; lookup scans until the match or the last cell.
// One item is in work at a time; a lookup walks the table one cell a cycle
// through the single read port of the cell memory and the shared compare
// unit.
// Synchronous reset empties the table, sets max_cells to 64 and drops any
// pending result. A stalled receiver holds the result; the block finishes its
// current item and then stalls its input until the output register drains.
module time_frequency_cell_lookup_core
    import tfcl_pkg::*;
#(
    parameter int DEPTH = TFCL_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_opcode,
    input  logic [TIME_W-1:0]   i_start_time,
    input  logic [TIME_W-1:0]   i_end_time,
    input  logic [FREQ_W-1:0]   i_lower_freq,
    input  logic [FREQ_W-1:0]   i_upper_freq,
    input  logic [PART_W-1:0]   i_part_code,
    input  logic [PSD_W-1:0]    i_psd_scale,
    input  logic [TIME_W-1:0]   i_query_time,
    input  logic [FREQ_W-1:0]   i_query_freq,

    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [INDEX_W-1:0]  o_cell_index,
    output logic [PART_W-1:0]   o_cell_part,
    output logic [PSD_W-1:0]    o_cell_psd,
    output logic [COUNT_W-1:0]  o_cell_count,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [COUNT_W-1:0]  i_cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_CHECK   = 5'b00010,
        S_COMPARE = 5'b00100,
        S_SCAN    = 5'b01000,
        S_DONE    = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    t_opcode            r_op;
    t_cell              r_new;
    logic [TIME_W-1:0]  r_qtime;
    logic [FREQ_W-1:0]  r_qfreq;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_scan_idx, n_scan_idx;
    logic [COUNT_W-1:0] r_max_cells;

    t_status            r_res_status, n_res_status;
    logic [AW-1:0]      r_res_index, n_res_index;
    logic [PART_W-1:0]  r_res_part, n_res_part;
    logic [PSD_W-1:0]   r_res_psd, n_res_psd;
    logic [CW-1:0]      r_res_count, n_res_count;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [INDEX_W-1:0] r_out_index;
    logic [PART_W-1:0]  r_out_part;
    logic [PSD_W-1:0]   r_out_psd;
    logic [COUNT_W-1:0] r_out_count;

    logic               in_xfer;
    logic               out_free;
    logic               out_load;
    logic               wr_en;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    t_cell              rd_entry;
    logic [TIME_W-1:0]  cmp_time;
    logic [FREQ_W-1:0]  cmp_freq;
    t_cmp_flags         flags;
    logic [LW-1:0]      cell_limit;
    logic               table_full;
    logic               hit;
    logic               order_err;
    logic               overlap_err;
    logic [IW-1:0]      res_index_ext;
    logic [LW-1:0]      res_count_ext;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign out_load    = (r_state == S_DONE) && out_free;

    // The table limit is the configured count clipped to the memory depth.
    assign cell_limit = (LW'(r_max_cells) < LW'(DEPTH)) ? LW'(r_max_cells) : LW'(DEPTH);
    assign table_full = (LW'(r_count) >= cell_limit);

    // Lookup compares the query; append compares its own start time and lower frequency against the last cell.
    assign cmp_time = (r_op == OP_LOOKUP) ? r_qtime : r_new.start_time;
    assign cmp_freq = (r_op == OP_LOOKUP) ? r_qfreq : r_new.lower_freq;

    tfcl_cmp_unit u_cmp (
        .i_query_time (cmp_time),
        .i_query_freq (cmp_freq),
        .i_entry      (rd_entry),
        .o_flags      (flags)
    );

    assign hit = flags.t_ge_start && flags.t_lt_end && flags.f_ge_lower && flags.f_lt_upper;
    assign order_err   = !flags.t_ge_start || (flags.t_eq_start && !flags.f_ge_lower);
    assign overlap_err = flags.t_eq_start && flags.f_lt_upper;

    tfcl_cell_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (AW'(r_count)),
        .i_wr_entry (r_new),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_scan_idx   = r_scan_idx;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_res_part   = r_res_part;
        n_res_psd    = r_res_psd;
        n_res_count  = r_res_count;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_res_status = ST_OK;
                    n_res_index  = '0;
                    n_res_part   = '0;
                    n_res_psd    = '0;
                    n_res_count  = r_count;
                    unique case (t_opcode'(i_opcode))
                        OP_CLEAR: begin
                            n_count     = '0;
                            n_res_count = '0;
                            n_state     = S_DONE;
                        end
                        OP_APPEND: begin
                            n_state = S_CHECK;
                        end
                        OP_LOOKUP: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                                n_state      = S_DONE;
                            end else begin
                                // Prefetch cell zero so the walk starts next cycle.
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                n_scan_idx = '0;
                                n_state    = S_SCAN;
                            end
                        end
                        OP_UNUSED: begin
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                n_state = S_DONE;
                if (r_new.start_time >= r_new.end_time) begin
                    n_res_status = ST_TIME;
                end else if (r_new.lower_freq >= r_new.upper_freq) begin
                    n_res_status = ST_FREQ;
                end else if (r_new.part_code == PART_INVALID) begin
                    n_res_status = ST_PART;
                end else if (r_new.psd_scale == '0) begin
                    n_res_status = ST_SCALE;
                end else if (table_full) begin
                    n_res_status = ST_FULL;
                end else if (r_count == '0) begin
                    wr_en       = 1'b1;
                    n_count     = r_count + CW'(1);
                    n_res_count = r_count + CW'(1);
                end else begin
                    // Fetch the last stored cell for the ordering checks.
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_count - CW'(1));
                    n_state = S_COMPARE;
                end
            end
            S_COMPARE: begin
                n_state = S_DONE;
                if (order_err) begin
                    n_res_status = ST_ORDER;
                end else if (overlap_err) begin
                    n_res_status = ST_OVERLAP;
                end else begin
                    wr_en       = 1'b1;
                    n_count     = r_count + CW'(1);
                    n_res_count = r_count + CW'(1);
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_res_status = ST_OK;
                    n_res_index  = r_scan_idx;
                    n_res_part   = rd_entry.part_code;
                    n_res_psd    = rd_entry.psd_scale;
                    n_state      = S_DONE;
                end else if ((CW'(r_scan_idx) + CW'(1)) == r_count) begin
                    n_res_status = ST_NOTFOUND;
                    n_state      = S_DONE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = r_scan_idx + AW'(1);
                    n_scan_idx = r_scan_idx + AW'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_max_cells <= MAX_CELLS_RST;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_cells <= i_cfg_data;
            end
        end
    end

    // Latch the item on transfer; hold it while the sequencer works.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op              <= t_opcode'(i_opcode);
            r_new.start_time  <= i_start_time;
            r_new.end_time    <= i_end_time;
            r_new.lower_freq  <= i_lower_freq;
            r_new.upper_freq  <= i_upper_freq;
            r_new.part_code   <= i_part_code;
            r_new.psd_scale   <= i_psd_scale;
            r_qtime           <= i_query_time;
            r_qfreq           <= i_query_freq;
        end
        r_scan_idx   <= n_scan_idx;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_res_part   <= n_res_part;
        r_res_psd    <= n_res_psd;
        r_res_count  <= n_res_count;
    end

    // Widen index and count to at least the result field widths; the output register keeps the low bits.
    assign res_index_ext = IW'(r_res_index);
    assign res_count_ext = LW'(r_res_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_index  <= res_index_ext[INDEX_W-1:0];
            r_out_part   <= r_res_part;
            r_out_psd    <= r_res_psd;
            r_out_count  <= res_count_ext[COUNT_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_cell_index = r_out_index;
    assign o_cell_part  = r_out_part;
    assign o_cell_psd   = r_out_psd;
    assign o_cell_count = r_out_count;

    // The table never holds more cells than the memory has entries.
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_count) <= LW'(DEPTH))
        else $error("cell count exceeds depth");

    // The lookup walk never reaches past the last stored cell.
    a_scan_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_scan_idx) < r_count))
        else $error("lookup scan beyond stored cells");

    // The input stalls right after a transfer, so two items are never taken back to back.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken twice in a row");

    // The count moves only on a transfer or an append decision.
    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> ($past(r_state) == S_IDLE || $past(r_state) == S_CHECK
                               || $past(r_state) == S_COMPARE))
        else $error("cell count changed outside an item decision");

endmodule
